>>> rtl/rc5rct_pkg.sv
// Package for the RC5 remote countdown timer: types, codes and constants.
`default_nettype none
package rc5rct_pkg;

   localparam int unsigned FRAME_BITS  = 14;
   localparam int unsigned TOGGLE_POS  = 2;
   localparam int unsigned CMD_POS     = 8;
   localparam int unsigned CMD_BITS    = 6;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [5:0] CMD_DIGIT_COUNT = 6'd10;
   localparam logic [5:0] CMD_STANDBY     = 6'd12;
   localparam logic [5:0] CMD_MUTE        = 6'd13;
   localparam logic [5:0] CMD_CLEAR       = 6'd15;
   localparam logic [5:0] CMD_OK          = 6'd47;

   localparam logic [15:0] START_MAX = 16'hFFFF;
   // Digits up to this one share one saturation limit, higher digits the other
   localparam logic [5:0]  DIGIT_SPLIT     = 6'd5;
   localparam logic [15:0] SAT_LIMIT_LOW   = 16'((65535 - 5) / 10);
   localparam logic [15:0] SAT_LIMIT_HIGH  = 16'((65535 - 9) / 10);

   localparam logic [1:0] CSR_LONG_INTERVAL  = 2'd0;
   localparam logic [1:0] CSR_SHORT_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_TOLERANCE      = 2'd2;
   localparam logic [1:0] CSR_MAX_BEEPS      = 2'd3;

   localparam logic [7:0] RESET_LONG_INTERVAL  = 8'd60;
   localparam logic [7:0] RESET_SHORT_INTERVAL = 8'd30;
   localparam logic [5:0] RESET_TOLERANCE      = 6'd15;
   localparam logic [3:0] RESET_MAX_BEEPS      = 4'd5;

   localparam logic [1:0] PERIOD_OFF  = 2'd0;
   localparam logic [1:0] PERIOD_ONE  = 2'd1;
   localparam logic [1:0] PERIOD_HALF = 2'd2;

   typedef enum logic [1:0] {
      MODE_CONFIG  = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_STOPPED = 2'd2,
      MODE_BEEPING = 2'd3
   } mode_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] interval;
   } req_type;

   typedef struct packed {
      logic        command_valid;
      logic [5:0]  command;
      logic [1:0]  mode;
      logic [15:0] start_time;
      logic [15:0] remaining;
      logic        beep;
      logic        show_remaining;
      logic [1:0]  tick_period;
   } rsp_type;

   typedef struct packed {
      logic [7:0] long_interval;
      logic [7:0] short_interval;
      logic [5:0] tolerance;
   } decode_cfg_type;

   // Classified item handed from the decoder to the timer
   typedef struct packed {
      logic       is_tick;
      logic       cmd_valid;
      logic [5:0] cmd;
   } event_type;

endpackage
`default_nettype wire

>>> rtl/rc5_remote_countdown_timer.sv
// A taken item is written into the event queue, and its result into the result queue, before it shows on the rsp_ side.
// Throughput: one item per cycle while neither queue is full; the timer state update in the back end sets it,
// with a two-entry queue between decoder and timer and another on the result side.
// Reset (synchronous, active high) empties both queues, clears decoder and timer
// state and loads the default intervals, tolerance and beep count.
`default_nettype none
module rc5_remote_countdown_timer #(
   parameter int unsigned QUEUE_DEPTH = rc5rct_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire rc5rct_pkg::req_type  req_item,
   output logic                      req_full,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output rc5rct_pkg::rsp_type       rsp_item,
   input  wire logic                 csr_write,
   input  wire logic [1:0]           csr_index,
   input  wire logic [7:0]           csr_wdata
);
   import rc5rct_pkg::*;

   decode_cfg_type cfg_ff;
   logic [3:0]     max_beeps_ff;
   logic           ev_full, ev_push, ev_empty, ev_pop;
   event_type      ev_in_item, ev_out_item;
   logic           rsp_full, rsp_push;
   rsp_type        rsp_in_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_interval  <= RESET_LONG_INTERVAL;
         cfg_ff.short_interval <= RESET_SHORT_INTERVAL;
         cfg_ff.tolerance      <= RESET_TOLERANCE;
         max_beeps_ff          <= RESET_MAX_BEEPS;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LONG_INTERVAL:  cfg_ff.long_interval  <= csr_wdata;
            CSR_SHORT_INTERVAL: cfg_ff.short_interval <= csr_wdata;
            CSR_TOLERANCE:      cfg_ff.tolerance      <= csr_wdata[5:0];
            CSR_MAX_BEEPS:      max_beeps_ff          <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   rc5rct_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .cfg      (cfg_ff),
      .ev_full  (ev_full),
      .ev_push  (ev_push),
      .ev_item  (ev_in_item)
   );

   rc5rct_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (event_type)
   ) u_ev_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_item (ev_in_item),
      .full      (ev_full),
      .pop       (ev_pop),
      .pop_item  (ev_out_item),
      .empty     (ev_empty)
   );

   rc5rct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_empty  (ev_empty),
      .ev_item   (ev_out_item),
      .ev_pop    (ev_pop),
      .max_beeps (max_beeps_ff),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_in_item)
   );

   rc5rct_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (rsp_type)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_in_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_item),
      .empty     (rsp_empty)
   );

endmodule
`default_nettype wire

>>> rtl/rc5rct_fifo.sv
// Small register queue used between the decoder and timer and on the result side.
`default_nettype none
module rc5rct_fifo #(
   parameter int unsigned DEPTH = 2,
   parameter type item_type = logic
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output item_type      pop_item,
   output logic          empty
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               wr_en, rd_en;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign wr_en = push && !full;
   assign rd_en = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/rc5rct_front.sv
// RC5 front end: classifies edge intervals, assembles frames, emits an event for every item.
`default_nettype none
module rc5rct_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   input  wire rc5rct_pkg::req_type       req_item,
   output logic                           req_full,
   input  wire rc5rct_pkg::decode_cfg_type cfg,
   input  wire logic                      ev_full,
   output logic                           ev_push,
   output rc5rct_pkg::event_type          ev_item
);
   import rc5rct_pkg::*;

   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [3:0]            count_ff, count_in;
   logic                  cur_ff, cur_in;
   logic                  aux_ff, aux_in;
   logic                  toggle_ff, toggle_in;
   logic                  is_long, is_short;
   logic                  store;
   logic                  tog;

   // Strict window: nominal - tol < v < nominal + tol, kept unsigned
   function automatic logic in_window(input logic [15:0] v, input logic [7:0] nom,
                                      input logic [5:0] tol);
      logic [16:0] hi;
      logic [16:0] v_plus;
      hi     = {9'd0, nom} + {11'd0, tol};
      v_plus = {1'b0, v} + {11'd0, tol};
      return ({1'b0, v} < hi) && (v_plus > {9'd0, nom});
   endfunction

   assign req_full = ev_full;
   assign ev_push  = req_push && !ev_full;
   assign is_long  = in_window(req_item.interval, cfg.long_interval, cfg.tolerance);
   assign is_short = in_window(req_item.interval, cfg.short_interval, cfg.tolerance);

   always_comb begin
      frame_in  = frame_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      aux_in    = aux_ff;
      toggle_in = toggle_ff;
      store     = 1'b0;
      tog       = 1'b0;
      ev_item.is_tick   = (req_item.kind == KIND_TICK);
      ev_item.cmd_valid = 1'b0;
      ev_item.cmd       = '0;
      if (req_item.kind == KIND_EDGE) begin
         if (is_long) begin
            cur_in = ~cur_ff;
            store  = 1'b1;
            aux_in = 1'b0;
         end else if (is_short) begin
            if (!aux_ff) begin
               aux_in = 1'b1;
            end else begin
               store  = 1'b1;
               aux_in = 1'b0;
            end
         end else begin
            // bad interval: restart the frame with a leading one
            count_in = '0;
            cur_in   = 1'b1;
            store    = 1'b1;
         end
         if (store) begin
            if (count_in < 4'(FRAME_BITS)) begin
               frame_in[count_in] = cur_in;
            end
            count_in = count_in + 4'd1;
         end
         if (count_in == 4'(FRAME_BITS)) begin
            tog      = frame_in[TOGGLE_POS];
            cur_in   = 1'b1;
            count_in = '0;
            if (tog != toggle_ff) begin
               toggle_in         = tog;
               ev_item.cmd_valid = 1'b1;
               for (int i = 0; i < CMD_BITS; i++) begin
                  ev_item.cmd[CMD_BITS-1-i] = frame_in[CMD_POS+i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff  <= '0;
         count_ff  <= '0;
         cur_ff    <= 1'b1;
         aux_ff    <= 1'b0;
         toggle_ff <= 1'b0;
      end else if (ev_push) begin
         frame_ff  <= frame_in;
         count_ff  <= count_in;
         cur_ff    <= cur_in;
         aux_ff    <= aux_in;
         toggle_ff <= toggle_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/rc5rct_back.sv
// Countdown timer back end: runs commands and ticks, builds one result per item.
`default_nettype none
module rc5rct_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   ev_empty,
   input  wire rc5rct_pkg::event_type  ev_item,
   output logic                        ev_pop,
   input  wire logic [3:0]             max_beeps,
   input  wire logic                   rsp_full,
   output logic                        rsp_push,
   output rc5rct_pkg::rsp_type         rsp_item
);
   import rc5rct_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        blink_ff, blink_in;
   logic [3:0]  beeps_ff, beeps_in;
   logic [5:0]  cmd_ff, cmd_in;
   logic        take;
   logic        go_run, go_cfg;
   logic [15:0] sat_limit;

   assign take     = !ev_empty && !rsp_full;
   assign ev_pop   = take;
   assign rsp_push = take;
   assign sat_limit = (ev_item.cmd <= DIGIT_SPLIT) ? SAT_LIMIT_LOW : SAT_LIMIT_HIGH;

   // next state
   always_comb begin
      mode_in    = mode_ff;
      start_in   = start_ff;
      elapsed_in = elapsed_ff;
      blink_in   = blink_ff;
      beeps_in   = beeps_ff;
      cmd_in     = cmd_ff;
      go_run     = 1'b0;
      go_cfg     = 1'b0;
      if (!ev_item.is_tick) begin
         if (ev_item.cmd_valid) begin
            cmd_in = ev_item.cmd;
            case (mode_ff)
               MODE_CONFIG: begin
                  if (ev_item.cmd < CMD_DIGIT_COUNT) begin
                     if (start_ff > sat_limit) begin
                        start_in = START_MAX;
                     end else begin
                        start_in = (start_ff << 3) + (start_ff << 1) + {10'd0, ev_item.cmd};
                     end
                  end else if (ev_item.cmd == CMD_CLEAR) begin
                     start_in = '0;
                  end else if (ev_item.cmd == CMD_OK) begin
                     go_run = 1'b1;
                  end
               end
               MODE_RUNNING: begin
                  if (ev_item.cmd == CMD_STANDBY) begin
                     mode_in = MODE_STOPPED;
                  end
               end
               MODE_STOPPED: begin
                  if (ev_item.cmd == CMD_OK) begin
                     go_run = 1'b1;
                  end else if (ev_item.cmd == CMD_CLEAR) begin
                     go_cfg = 1'b1;
                  end
               end
               MODE_BEEPING: begin
                  if (ev_item.cmd == CMD_MUTE) begin
                     go_cfg = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end else begin
         case (mode_ff)
            MODE_RUNNING: begin
               elapsed_in = elapsed_ff + 16'd1;
               if (start_ff == elapsed_in) begin
                  mode_in = MODE_BEEPING;
               end
            end
            MODE_STOPPED: blink_in = ~blink_ff;
            MODE_BEEPING: begin
               beeps_in = beeps_ff + 4'd1;
               if (beeps_in == max_beeps) begin
                  go_cfg = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (go_run) begin
         mode_in = (start_ff == '0) ? MODE_BEEPING : MODE_RUNNING;
      end
      if (go_cfg) begin
         mode_in    = MODE_CONFIG;
         start_in   = '0;
         elapsed_in = '0;
         beeps_in   = '0;
      end
   end

   // outputs
   always_comb begin
      rsp_item.command_valid  = !ev_item.is_tick && ev_item.cmd_valid;
      rsp_item.command        = cmd_in;
      rsp_item.mode           = mode_in;
      rsp_item.start_time     = start_in;
      rsp_item.remaining      = start_in - elapsed_in;
      rsp_item.beep           = ev_item.is_tick && (mode_ff == MODE_BEEPING);
      rsp_item.show_remaining = !(ev_item.is_tick && (mode_ff == MODE_STOPPED) && !blink_ff);
      case (mode_in)
         MODE_CONFIG:  rsp_item.tick_period = PERIOD_OFF;
         MODE_STOPPED: rsp_item.tick_period = PERIOD_HALF;
         default:      rsp_item.tick_period = PERIOD_ONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_CONFIG;
         start_ff   <= '0;
         elapsed_ff <= '0;
         blink_ff   <= 1'b0;
         beeps_ff   <= '0;
         cmd_ff     <= '0;
      end else if (take) begin
         mode_ff    <= mode_in;
         start_ff   <= start_in;
         elapsed_ff <= elapsed_in;
         blink_ff   <= blink_in;
         beeps_ff   <= beeps_in;
         cmd_ff     <= cmd_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/rc5rct_checker.sv
// Port-level checks for the RC5 countdown timer, bound to the top level.
`default_nettype none
module rc5rct_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_full,
   input wire logic                 rsp_empty,
   input wire rc5rct_pkg::rsp_type  rsp_item
);
   import rc5rct_pkg::*;

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_period: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
         ((rsp_item.mode == MODE_CONFIG) && (rsp_item.tick_period == PERIOD_OFF)) ||
         ((rsp_item.mode == MODE_STOPPED) && (rsp_item.tick_period == PERIOD_HALF)) ||
         ((rsp_item.mode == MODE_RUNNING) && (rsp_item.tick_period == PERIOD_ONE)) ||
         ((rsp_item.mode == MODE_BEEPING) && (rsp_item.tick_period == PERIOD_ONE)))
      else $error("tick period does not match mode");

   a_beep_mode: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.beep) |->
         (rsp_item.mode == MODE_BEEPING) || (rsp_item.mode == MODE_CONFIG))
      else $error("beep outside beeping");

   a_dashes_stopped: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_item.show_remaining) |-> (rsp_item.mode == MODE_STOPPED))
      else $error("dashes outside stopped mode");

   // elapsed is always clear in config
   a_config_full: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_item.mode == MODE_CONFIG)) |->
         (rsp_item.remaining == rsp_item.start_time))
      else $error("remaining differs from start in config");

endmodule

bind rc5_remote_countdown_timer rc5rct_checker u_checker (.*);
`default_nettype wire

>>> tb/tb_rc5_remote_countdown_timer.sv
// Self-checking testbench for the RC5 remote countdown timer: directed and random items.
`timescale 1ns / 1ps
module tb_rc5_remote_countdown_timer;
   import rc5rct_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_SLACK  = 8;
   localparam int STALL_CYCLES = 200;
   localparam int MAX_REPORTS  = 10;
   localparam int TIMEOUT_NS   = 2_000_000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   req_type    req_item = '0;
   logic       req_full;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   rsp_type    rsp_item;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = CSR_LONG_INTERVAL;
   logic [7:0] csr_wdata = '0;

   rc5_remote_countdown_timer DUT (
      .clock, .reset, .req_push, .req_item, .req_full, .rsp_empty, .rsp_pop, .rsp_item,
      .csr_write, .csr_index, .csr_wdata
   );

   always #HALF_PERIOD clock = ~clock;

   // Mirror of the block: registers
   logic [7:0] cfg_long = RESET_LONG_INTERVAL;
   logic [7:0] cfg_short = RESET_SHORT_INTERVAL;
   logic [5:0] cfg_tol = RESET_TOLERANCE;
   logic [3:0] cfg_max_beeps = RESET_MAX_BEEPS;

   // Mirror of the block: decoder and timer state
   logic [13:0] dec_bits = '0;
   logic [3:0]  dec_count = '0;
   logic        dec_level = 1'b1;
   logic        dec_half = 1'b0;
   logic        seen_toggle = 1'b0;
   logic [5:0]  cur_command = '0;
   mode_type    tmode = MODE_CONFIG;
   logic [15:0] start_secs = '0;
   logic [15:0] elapsed_secs = '0;
   logic        blink_phase = 1'b0;
   logic [3:0]  beeps_done = '0;

   req_type ir_events[$];
   rsp_type status_due[$];

   // Stimulus-side shadow of the half-bit flag, and the toggle last sent
   logic gen_half = 1'b0;
   logic gen_toggle = 1'b0;
   int unsigned queued_items = 0;

   int unsigned tx_idle_pct = 33;
   int unsigned rx_idle_pct = 47;
   logic        rx_hold = 1'b0;
   logic        req_taken = 1'b0;
   event        stall_kick;

   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned edges_sent = 0;
   int unsigned ticks_sent = 0;
   int unsigned cmds_seen = 0;
   int unsigned beeps_seen = 0;
   int unsigned sat_seen = 0;
   int unsigned full_stalls = 0;
   int unsigned mode_seen [4] = '{default: 0};

   function automatic logic win_hit(logic [15:0] iv, logic [7:0] nom);
      int v, n, t;
      v = iv;
      n = nom;
      t = cfg_tol;
      return (v < n + t) && (v > n - t);
   endfunction

   task automatic latch_level();
      if (dec_count < FRAME_BITS) dec_bits[dec_count] = dec_level;
      dec_count = dec_count + 4'd1;
   endtask

   task automatic switch_mode(mode_type m);
      if (m == MODE_RUNNING && start_secs == 16'd0) m = MODE_BEEPING;
      tmode = m;
      if (m == MODE_CONFIG) begin
         elapsed_secs = '0;
         start_secs = '0;
         beeps_done = '0;
      end
   endtask

   task automatic apply_command(logic [5:0] cmd);
      int room;
      case (tmode)
         MODE_CONFIG: begin
            if (cmd < CMD_DIGIT_COUNT) begin
               room = (int'(START_MAX) - int'(cmd)) / 10;
               if (room < int'(start_secs)) start_secs = START_MAX;
               else start_secs = 16'(start_secs * 10 + cmd);
            end else if (cmd == CMD_CLEAR) begin
               start_secs = '0;
            end else if (cmd == CMD_OK) begin
               switch_mode(MODE_RUNNING);
            end
         end
         MODE_RUNNING: begin
            if (cmd == CMD_STANDBY) switch_mode(MODE_STOPPED);
         end
         MODE_STOPPED: begin
            if (cmd == CMD_OK) switch_mode(MODE_RUNNING);
            else if (cmd == CMD_CLEAR) switch_mode(MODE_CONFIG);
         end
         default: begin
            if (cmd == CMD_MUTE) switch_mode(MODE_CONFIG);
         end
      endcase
   endtask

   // Advances the mirror by one item and gives the status the block should report
   task automatic predict_status(input req_type it, output rsp_type st);
      logic [5:0] cmd;
      int i;
      st = '0;
      st.show_remaining = 1'b1;
      if (it.kind == KIND_EDGE) begin
         if (win_hit(it.interval, cfg_long)) begin
            dec_level = ~dec_level;
            latch_level();
            dec_half = 1'b0;
         end else if (win_hit(it.interval, cfg_short)) begin
            if (!dec_half) begin
               dec_half = 1'b1;
            end else begin
               latch_level();
               dec_half = 1'b0;
            end
         end else begin
            // bad interval restarts the frame; half-bit flag is left alone
            dec_count = '0;
            dec_level = 1'b1;
            latch_level();
         end
         if (dec_count == FRAME_BITS) begin
            dec_level = 1'b1;
            dec_count = '0;
            if (dec_bits[TOGGLE_POS] != seen_toggle) begin
               seen_toggle = dec_bits[TOGGLE_POS];
               cmd = '0;
               for (i = CMD_POS; i < FRAME_BITS; i++) cmd = {cmd[4:0], dec_bits[i]};
               cur_command = cmd;
               st.command_valid = 1'b1;
               apply_command(cmd);
            end
         end
      end else begin
         case (tmode)
            MODE_RUNNING: begin
               elapsed_secs = elapsed_secs + 16'd1;
               if (16'(start_secs - elapsed_secs) == 16'd0) switch_mode(MODE_BEEPING);
            end
            MODE_STOPPED: begin
               st.show_remaining = blink_phase;
               blink_phase = ~blink_phase;
            end
            MODE_BEEPING: begin
               st.beep = 1'b1;
               beeps_done = beeps_done + 4'd1;
               if (beeps_done == cfg_max_beeps) switch_mode(MODE_CONFIG);
            end
            default: ;
         endcase
      end
      st.command = cur_command;
      st.mode = tmode;
      st.start_time = start_secs;
      st.remaining = start_secs - elapsed_secs;
      if (tmode == MODE_CONFIG) st.tick_period = PERIOD_OFF;
      else if (tmode == MODE_STOPPED) st.tick_period = PERIOD_HALF;
      else st.tick_period = PERIOD_ONE;
   endtask

   task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("result %0d: %s expected %0d, got %0d", results_seen, fname, want, got);
      end
   endtask

   // Monitor: results are checked before the new item is predicted
   always @(posedge clock) begin
      rsp_type want, got;
      req_taken = 1'b0;
      if (!reset) begin
         if (!rsp_empty && rsp_pop) begin
            got = rsp_item;
            results_seen++;
            if (status_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result %0d arrived with nothing pending: %p", results_seen, got);
            end else begin
               want = status_due.pop_front();
               check_field("command_valid", want.command_valid, got.command_valid);
               check_field("command", want.command, got.command);
               check_field("mode", want.mode, got.mode);
               check_field("start_time", want.start_time, got.start_time);
               check_field("remaining", want.remaining, got.remaining);
               check_field("beep", want.beep, got.beep);
               check_field("show_remaining", want.show_remaining, got.show_remaining);
               check_field("tick_period", want.tick_period, got.tick_period);
               mode_seen[want.mode]++;
               if (want.command_valid) cmds_seen++;
               if (want.beep) beeps_seen++;
               if (want.start_time == START_MAX) sat_seen++;
            end
         end
         if (req_push && !req_full) begin
            predict_status(req_item, want);
            status_due.push_back(want);
            req_taken = 1'b1;
            if (req_item.kind == KIND_EDGE) edges_sent++;
            else ticks_sent++;
         end else if (req_push) begin
            full_stalls++;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_LONG_INTERVAL:  cfg_long = csr_wdata;
               CSR_SHORT_INTERVAL: cfg_short = csr_wdata;
               CSR_TOLERANCE:      cfg_tol = csr_wdata[5:0];
               CSR_MAX_BEEPS:      cfg_max_beeps = csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   // Driver: an offered item stays until taken
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_taken) begin
         if (ir_events.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_item <= ir_events.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
   end

   // Long receiver hold-off so the block fills and pushes back
   initial begin
      forever begin
         @(stall_kick);
         rx_hold = 1'b1;
         repeat (STALL_CYCLES) @(posedge clock);
         rx_hold = 1'b0;
      end
   end

   function automatic logic [15:0] pick_in_window(logic [7:0] nom);
      int lo, hi;
      lo = int'(nom) - int'(cfg_tol) + 1;
      hi = int'(nom) + int'(cfg_tol) - 1;
      if (lo < 0) lo = 0;
      if (hi < lo) return 16'(nom);
      return 16'($urandom_range(hi, lo));
   endfunction

   // Half-bit interval, redrawn up to eight times to keep it clear of the long window where the windows overlap
   function automatic logic [15:0] pick_short();
      logic [15:0] v;
      int k;
      v = pick_in_window(cfg_short);
      for (k = 0; k < 8 && win_hit(v, cfg_long); k++) v = pick_in_window(cfg_short);
      return v;
   endfunction

   function automatic logic [15:0] pick_outside();
      int v;
      case ($urandom_range(3))
         0: v = int'(cfg_long) + int'(cfg_tol);
         1: v = int'(cfg_short) - int'(cfg_tol);
         2: v = $urandom_range(65535, 32768);
         default: v = $urandom_range(65535);
      endcase
      if (v < 0 || win_hit(16'(v), cfg_long) || win_hit(16'(v), cfg_short)) return '1;
      return 16'(v);
   endfunction

   task automatic queue_edge(logic [15:0] iv);
      req_type it;
      if (win_hit(iv, cfg_long)) gen_half = 1'b0;
      else if (win_hit(iv, cfg_short)) gen_half = ~gen_half;
      it.kind = KIND_EDGE;
      it.interval = iv;
      ir_events.push_back(it);
      queued_items++;
   endtask

   task automatic queue_tick();
      req_type it;
      it.kind = KIND_TICK;
      it.interval = 16'($urandom);
      ir_events.push_back(it);
      queued_items++;
   endtask

   // filler carries frame bit 1 in bit 0 and frame bits 7..3 in bits 5..1
   task automatic queue_frame(logic [5:0] cmd, logic tog, logic [5:0] filler);
      logic [13:0] fb;
      int i;
      fb = {cmd[0], cmd[1], cmd[2], cmd[3], cmd[4], cmd[5], filler[5:1], tog, filler[0], 1'b1};
      queue_edge(pick_outside());
      for (i = 1; i < FRAME_BITS; i++) begin
         if (fb[i] != fb[i-1]) begin
            queue_edge(pick_in_window(cfg_long));
         end else begin
            if (!gen_half) queue_edge(pick_short());
            queue_edge(pick_short());
         end
      end
      gen_toggle = tog;
   endtask

   // Mostly a fresh key press; now and then a repeat with the same toggle
   task automatic queue_command(logic [5:0] cmd);
      queue_frame(cmd, ($urandom_range(9) == 0) ? gen_toggle : ~gen_toggle, 6'($urandom));
   endtask

   task automatic queue_scenario();
      int pick, n, r;
      pick = $urandom_range(99);
      if (pick < 40) begin
         r = $urandom_range(99);
         if (r < 35) queue_command(6'($urandom_range(9)));
         else if (r < 50) queue_command(CMD_OK);
         else if (r < 60) queue_command(CMD_STANDBY);
         else if (r < 70) queue_command(CMD_CLEAR);
         else if (r < 80) queue_command(CMD_MUTE);
         else queue_command(6'($urandom));
         repeat ($urandom_range(4)) queue_tick();
      end else if (pick < 60) begin
         // from any mode back to config, enter a time, start it and tick; short times may run down and beep
         queue_command(CMD_MUTE);
         queue_command(CMD_STANDBY);
         queue_command(CMD_CLEAR);
         n = ($urandom_range(3) == 0) ? $urandom_range(6, 5) : 1;
         repeat (n) queue_command(6'($urandom_range(n == 1 ? 3 : 9)));
         queue_command(CMD_OK);
         repeat ($urandom_range(4)) queue_tick();
         if ($urandom_range(1)) begin
            queue_command(CMD_STANDBY);
            repeat ($urandom_range(4, 1)) queue_tick();
            queue_command(CMD_OK);
         end
         repeat ($urandom_range(18)) queue_tick();
      end else if (pick < 75) begin
         repeat ($urandom_range(10, 1)) queue_tick();
      end else if (pick < 88) begin
         repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(3))
               0: queue_edge(pick_in_window(cfg_long));
               1: queue_edge(pick_short());
               2: queue_edge(pick_outside());
               default: queue_edge(16'($urandom_range(400)));
            endcase
         end
      end else begin
         // a bad interval starts a frame that is left incomplete
         queue_edge(pick_outside());
         repeat ($urandom_range(8, 1))
            queue_edge($urandom_range(1) ? pick_in_window(cfg_long) : pick_short());
      end
   endtask

   // Samples after the falling edge so driver updates have settled
   task automatic wait_drained();
      while (ir_events.size() != 0 || req_push || status_due.size() != 0) begin
         @(negedge clock);
         #1;
      end
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_config(logic [7:0] lng, logic [7:0] shrt, logic [7:0] tol,
                             logic [7:0] beeps);
      write_reg(CSR_LONG_INTERVAL, lng);
      write_reg(CSR_SHORT_INTERVAL, shrt);
      write_reg(CSR_TOLERANCE, tol);
      write_reg(CSR_MAX_BEEPS, beeps);
   endtask

   // The last scenario of a phase runs past its target, so targets sit below the share
   task automatic run_phase(int unsigned n_items, int unsigned tx_pct, int unsigned rx_pct,
                            logic squeeze);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      if (squeeze) -> stall_kick;
      queued_items = 0;
      while (queued_items < n_items) queue_scenario();
      wait_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: window edges around the default intervals, huge intervals, one frame
      queue_tick();
      queue_edge('1);
      queue_edge(16'h8000);
      queue_edge(RESET_LONG_INTERVAL - RESET_TOLERANCE);
      queue_edge(RESET_LONG_INTERVAL + RESET_TOLERANCE - 8'd1);
      queue_edge(RESET_LONG_INTERVAL + RESET_TOLERANCE);
      queue_edge(RESET_SHORT_INTERVAL - RESET_TOLERANCE + 8'd1);
      queue_edge(RESET_SHORT_INTERVAL + RESET_TOLERANCE - 8'd1);
      // start at zero goes straight to beeping
      queue_frame(CMD_OK, 1'b1, 6'b010100);
      queue_tick();
      wait_drained();

      run_phase(200, 33, 47, 1'b1);
      set_config(8'd255, 8'd0, 8'hFF, 8'd15);
      run_phase(130, 33, 47, 1'b0);
      set_config(8'd0, 8'd255, 8'd1, 8'd1);
      run_phase(100, 47, 33, 1'b0);
      // overlapping windows; beep limit written as zero
      set_config(8'd40, 8'd30, 8'd15, 8'hF0);
      run_phase(130, 47, 33, 1'b0);
      // zero tolerance: no interval ever matches
      set_config(8'd0, 8'd0, 8'd0, 8'd3);
      run_phase(40, 47, 33, 1'b0);
      set_config(8'd100, 8'd50, 8'd20, 8'd2);
      run_phase(160, 0, 0, 1'b1);

      $display("Run covered %0d items (%0d IR edges, %0d ticks) over six register settings,",
               edges_sent + ticks_sent, edges_sent, ticks_sent);
      $display("%0d commands, %0d beeps, modes %0d/%0d/%0d/%0d, %0d saturated, %0d full cycles",
               cmds_seen, beeps_seen, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
               sat_seen, full_stalls);
      if (mismatches == 0 && status_due.size() == 0) begin
         $display("PASS rc5_remote_countdown_timer");
      end else begin
         $display("FAIL rc5_remote_countdown_timer");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL rc5_remote_countdown_timer");
      $finish;
   end

endmodule
